[sv/pls_pkg.sv]
// Shared definitions for the positional list store: op and status codes,
// cell command codes and the command struct broadcast along the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 8;
  localparam int STATUS_W   = 3;
  // index width that covers the largest supported depth (64 cells)
  localparam int IDX_W      = 6;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  localparam logic [1:0] CMD_HOLD = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx;
  } pls_ctrl_t;

endpackage

`default_nettype wire

[sv/positional_list_store_core.sv]
// Positional list store top level: request decode, count, dump sequencing,
// result register with skid stage, and the row of pls_cell storage cells.
// Depends on pls_pkg and pls_cell.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  in_op, in_value, in_position
//   out      out  out_valid/out_stall out_status, out_element, out_last
//
// An edit shifts the affected cells in parallel and one result beat is
// produced. A dump emits count beats: the row rotates one place per
// result beat, the head cell feeding the output, so the list is intact after.
// rst_n clears the count and all handshake state; cell contents are not reset.
// A stalled output holds one beat in the result register and one in the skid
// stage; input stalls while a dump runs or the skid stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_core #(
  parameter int LIST_DEPTH = pls_pkg::LIST_DEPTH
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [pls_pkg::OP_W-1:0]              in_op,
  input  wire  signed [pls_pkg::DATA_W-1:0]     in_value,
  input  wire  [pls_pkg::POS_W-1:0]             in_position,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [pls_pkg::STATUS_W-1:0]          out_status,
  output logic signed [pls_pkg::DATA_W-1:0]     out_element,
  output logic                                  out_last
);

  localparam int DW = pls_pkg::DATA_W;
  localparam int SW = pls_pkg::STATUS_W;
  localparam int IW = pls_pkg::IDX_W;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;

  logic [CW-1:0] count_r, count_nxt;
  logic          dumping_r, dumping_nxt;
  logic [CW-1:0] dump_rem_r, dump_rem_nxt;

  logic          out_v_r;
  logic [SW-1:0] out_status_r;
  logic [DW-1:0] out_element_r;
  logic          out_last_r;

  logic          skid_v_r;
  logic [SW-1:0] skid_status_r;
  logic [DW-1:0] skid_element_r;
  logic          skid_last_r;

  logic          in_acc;
  logic          dump_go;
  logic          full;
  logic          empty;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] pos_ext;

  logic [SW-1:0] ed_status;
  logic [1:0]    ed_cmd;
  logic [IW-1:0] ed_idx;

  pls_pkg::pls_ctrl_t ctrl;

  logic          r_valid;
  logic [SW-1:0] r_status;
  logic [DW-1:0] r_element;
  logic          r_last;

  logic [DW-1:0] cell_q [LIST_DEPTH];

  assign in_stall = dumping_r | skid_v_r;
  assign in_acc   = in_valid & ~in_stall;
  assign dump_go  = dumping_r & ~skid_v_r & (~out_v_r | ~out_stall);
  assign full     = (count_r == CW'(LIST_DEPTH));
  assign empty    = (count_r == '0);
  assign cnt_ext  = PW'(count_r);
  assign pos_ext  = PW'(in_position);

  always_comb begin
    ed_status = pls_pkg::ST_OK;
    ed_cmd    = pls_pkg::CMD_HOLD;
    ed_idx    = '0;
    case (in_op)
      pls_pkg::OP_INS_FRONT: begin
        if (full) begin
          ed_status = pls_pkg::ST_FULL;
        end else begin
          ed_cmd = pls_pkg::CMD_INS;
        end
      end
      pls_pkg::OP_INS_END: begin
        if (full) begin
          ed_status = pls_pkg::ST_FULL;
        end else begin
          ed_cmd = pls_pkg::CMD_INS;
          ed_idx = IW'(count_r);
        end
      end
      pls_pkg::OP_INS_POS: begin
        if (in_position == '0) begin
          ed_status = pls_pkg::ST_INVALID;
        end else if (pos_ext > cnt_ext + PW'(1)) begin
          ed_status = pls_pkg::ST_RANGE;
        end else if (full) begin
          ed_status = pls_pkg::ST_FULL;
        end else begin
          ed_cmd = pls_pkg::CMD_INS;
          ed_idx = IW'(in_position - pls_pkg::POS_W'(1));
        end
      end
      pls_pkg::OP_DEL_FRONT: begin
        if (empty) begin
          ed_status = pls_pkg::ST_EMPTY;
        end else begin
          ed_cmd = pls_pkg::CMD_DEL;
        end
      end
      pls_pkg::OP_DEL_END: begin
        if (empty) begin
          ed_status = pls_pkg::ST_EMPTY;
        end else begin
          ed_cmd = pls_pkg::CMD_DEL;
          ed_idx = IW'(count_r - CW'(1));
        end
      end
      pls_pkg::OP_DEL_POS: begin
        if (empty) begin
          ed_status = pls_pkg::ST_EMPTY;
        end else if (in_position == '0) begin
          ed_status = pls_pkg::ST_INVALID;
        end else if (pos_ext > cnt_ext) begin
          ed_status = pls_pkg::ST_RANGE;
        end else begin
          ed_cmd = pls_pkg::CMD_DEL;
          ed_idx = IW'(in_position - pls_pkg::POS_W'(1));
        end
      end
      pls_pkg::OP_DUMP: begin
        if (empty) begin
          ed_status = pls_pkg::ST_EMPTY;
        end
      end
      default: ed_status = pls_pkg::ST_INVALID;
    endcase
  end

  always_comb begin
    ctrl.cmd = pls_pkg::CMD_HOLD;
    ctrl.idx = IW'(count_r - CW'(1));
    if (dumping_r) begin
      if (dump_go) begin
        ctrl.cmd = pls_pkg::CMD_ROT;
      end
    end else if (in_acc) begin
      ctrl.cmd = ed_cmd;
      ctrl.idx = ed_idx;
    end
  end

  always_comb begin
    count_nxt    = count_r;
    dumping_nxt  = dumping_r;
    dump_rem_nxt = dump_rem_r;
    if (dumping_r) begin
      r_valid   = dump_go;
      r_status  = pls_pkg::ST_OK;
      r_element = cell_q[0];
      r_last    = (dump_rem_r == CW'(1));
      if (dump_go) begin
        dump_rem_nxt = dump_rem_r - CW'(1);
        if (dump_rem_r == CW'(1)) begin
          dumping_nxt = 1'b0;
        end
      end
    end else begin
      r_valid   = in_acc & ~((in_op == pls_pkg::OP_DUMP) & ~empty);
      r_status  = ed_status;
      r_element = '0;
      r_last    = 1'b1;
      if (in_acc) begin
        if (in_op == pls_pkg::OP_DUMP && !empty) begin
          dumping_nxt  = 1'b1;
          dump_rem_nxt = count_r;
        end
        if (ed_cmd == pls_pkg::CMD_INS) begin
          count_nxt = count_r + CW'(1);
        end else if (ed_cmd == pls_pkg::CMD_DEL) begin
          count_nxt = count_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dumping_r  <= 1'b0;
      dump_rem_r <= '0;
      out_v_r    <= 1'b0;
      skid_v_r   <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      dumping_r  <= dumping_nxt;
      dump_rem_r <= dump_rem_nxt;
      if (out_v_r && out_stall) begin
        if (r_valid) begin
          skid_v_r <= 1'b1;
        end
      end else if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= r_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && out_stall) begin
      if (r_valid) begin
        skid_status_r  <= r_status;
        skid_element_r <= r_element;
        skid_last_r    <= r_last;
      end
    end else if (skid_v_r) begin
      out_status_r  <= skid_status_r;
      out_element_r <= skid_element_r;
      out_last_r    <= skid_last_r;
    end else if (r_valid) begin
      out_status_r  <= r_status;
      out_element_r <= r_element;
      out_last_r    <= r_last;
    end
  end

  assign out_valid   = out_v_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [DW-1:0] left_d;
    logic [DW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_end
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    pls_cell #(
      .POS    (g),
      .DATA_W (DW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_data   (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_q[0]),
      .q          (cell_q[g])
    );
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("count exceeds depth");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid beat without output beat");

  a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |-> (dump_rem_r != '0) && (dump_rem_r <= count_r))
    else $error("dump counter out of bounds");

  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op != pls_pkg::OP_DUMP) |=> out_v_r)
    else $error("edit produced no result beat");

  a_dump_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    dumping_r |=> $stable(count_r))
    else $error("count changed during dump");
`endif

endmodule

`default_nettype wire

[sv/pls_cell.sv]
// One storage cell of the positional list store: holds one entry and
// loads it from its left or right neighbor, the insert value or the head.
// Depends on pls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pls_cell #(
  parameter int POS    = 0,
  parameter int DATA_W = pls_pkg::DATA_W
) (
  input  wire                    clk,
  input  wire pls_pkg::pls_ctrl_t ctrl,
  input  wire  [DATA_W-1:0]      ins_data,
  input  wire  [DATA_W-1:0]      left_data,
  input  wire  [DATA_W-1:0]      right_data,
  input  wire  [DATA_W-1:0]      head_data,
  output logic [DATA_W-1:0]      q
);

  localparam int IW = pls_pkg::IDX_W;
  localparam logic [IW-1:0] MY_IDX = IW'(POS);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      pls_pkg::CMD_INS: begin
        if (MY_IDX > ctrl.idx) begin
          data_nxt = left_data;
        end else if (MY_IDX == ctrl.idx) begin
          data_nxt = ins_data;
        end
      end
      pls_pkg::CMD_DEL: begin
        if (MY_IDX >= ctrl.idx) begin
          data_nxt = right_data;
        end
      end
      pls_pkg::CMD_ROT: begin
        if (MY_IDX == ctrl.idx) begin
          data_nxt = head_data;
        end else if (MY_IDX < ctrl.idx) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for positional_list_store_core: a directed table, then random
// edit and dump traffic with idle gaps and stalls, checked beat by beat against a shadow list.
// Depends on pls_pkg and the positional_list_store_core RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int LIST_DEPTH   = pls_pkg::LIST_DEPTH;
  localparam int DATA_W       = pls_pkg::DATA_W;
  localparam int OP_W         = pls_pkg::OP_W;
  localparam int POS_W        = pls_pkg::POS_W;
  localparam int STATUS_W     = pls_pkg::STATUS_W;
  localparam int CLK_PERIOD   = 10;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 80;
  localparam int TOTAL_ITEMS  = 150;
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   element;
    logic                last;
  } list_beat_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [DATA_W-1:0]   value;
    logic [POS_W-1:0]    position;
    logic                typed;
    logic [STATUS_W-1:0] status;
  } table_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op;
  logic signed [DATA_W-1:0] in_value;
  logic [POS_W-1:0]         in_position;
  logic                     out_valid;
  logic                     out_stall;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_element;
  logic                     out_last;

  logic [DATA_W-1:0] shadow_list[$];
  list_beat_t        due_beats[$];
  table_row_t        table_rows[$];
  list_beat_t        want;
  int                mismatches;
  int                cycle_cnt;
  int                sent_items;
  bit                calm;
  bit                hold_req;

  positional_list_store_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_value(in_value),
    .in_position(in_position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_element(out_element),
    .out_last(out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 32'h8000_0000;
    if (r < 16) return 32'h7fff_ffff;
    if (r < 20) return '0;
    if (r < 24) return '1;
    return DATA_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input int bound);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(1, (bound < 1) ? 1 : bound));
  endfunction

  task automatic push_beat(input logic [STATUS_W-1:0] st, input logic [DATA_W-1:0] elem,
                           input logic lst);
    list_beat_t b;
    b.status  = st;
    b.element = elem;
    b.last    = lst;
    due_beats.push_back(b);
  endtask

  task automatic apply_list_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                                    input logic [POS_W-1:0] pos);
    logic [STATUS_W-1:0] st;
    int cnt;
    int p;
    st  = pls_pkg::ST_OK;
    cnt = shadow_list.size();
    p   = int'(pos);
    if (op == pls_pkg::OP_DUMP) begin
      if (cnt == 0) begin
        push_beat(pls_pkg::ST_EMPTY, '0, 1'b1);
      end else begin
        for (int i = 0; i < cnt; i++) push_beat(pls_pkg::ST_OK, shadow_list[i], i == cnt - 1);
      end
    end else begin
      case (op)
        pls_pkg::OP_INS_FRONT: begin
          if (cnt >= LIST_DEPTH) st = pls_pkg::ST_FULL;
          else shadow_list.push_front(val);
        end
        pls_pkg::OP_INS_END: begin
          if (cnt >= LIST_DEPTH) st = pls_pkg::ST_FULL;
          else shadow_list.push_back(val);
        end
        pls_pkg::OP_INS_POS: begin
          if (p == 0) st = pls_pkg::ST_INVALID;
          else if (p > cnt + 1) st = pls_pkg::ST_RANGE;
          else if (cnt >= LIST_DEPTH) st = pls_pkg::ST_FULL;
          else shadow_list.insert(p - 1, val);
        end
        pls_pkg::OP_DEL_FRONT: begin
          if (cnt == 0) st = pls_pkg::ST_EMPTY;
          else void'(shadow_list.pop_front());
        end
        pls_pkg::OP_DEL_END: begin
          if (cnt == 0) st = pls_pkg::ST_EMPTY;
          else void'(shadow_list.pop_back());
        end
        pls_pkg::OP_DEL_POS: begin
          if (cnt == 0) st = pls_pkg::ST_EMPTY;
          else if (p == 0) st = pls_pkg::ST_INVALID;
          else if (p > cnt) st = pls_pkg::ST_RANGE;
          else shadow_list.delete(p - 1);
        end
        default: st = pls_pkg::ST_INVALID;
      endcase
      push_beat(st, '0, 1'b1);
    end
  endtask

  task automatic send_req(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos, input logic typed,
                          input logic [STATUS_W-1:0] typed_st);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    apply_list_request(op, val, pos);
    if (typed) begin
      void'(due_beats.pop_back());
      push_beat(typed_st, '0, 1'b1);
    end
    sent_items++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                         input logic [POS_W-1:0] pos, input logic typed,
                         input logic [STATUS_W-1:0] st);
    table_row_t row;
    row.op       = op;
    row.value    = val;
    row.position = pos;
    row.typed    = typed;
    row.status   = st;
    table_rows.push_back(row);
  endtask

  task automatic send_random_item();
    int r;
    int cnt;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    r   = $urandom_range(0, 99);
    cnt = shadow_list.size();
    if (r < 3) op = OP_SPARE;
    else op = OP_W'($urandom_range(pls_pkg::OP_INS_FRONT, pls_pkg::OP_DUMP));
    if (op == pls_pkg::OP_INS_POS) pos = pick_position(cnt + 1);
    else if (op == pls_pkg::OP_DEL_POS) pos = pick_position(cnt);
    else pos = POS_W'($urandom_range(0, 255));
    send_req(op, pick_value(), pos, 1'b0, pls_pkg::ST_OK);
  endtask

  task automatic fill_list();
    logic [OP_W-1:0] op;
    while (shadow_list.size() < LIST_DEPTH) begin
      op = OP_W'($urandom_range(pls_pkg::OP_INS_FRONT, pls_pkg::OP_INS_POS));
      send_req(op, pick_value(), POS_W'($urandom_range(1, shadow_list.size() + 1)), 1'b0,
               pls_pkg::ST_OK);
    end
    send_req(pls_pkg::OP_INS_FRONT, pick_value(), 8'd0, 1'b0, pls_pkg::ST_OK);
    send_req(pls_pkg::OP_INS_END, pick_value(), 8'd0, 1'b0, pls_pkg::ST_OK);
    send_req(pls_pkg::OP_INS_POS, pick_value(), POS_W'($urandom_range(1, LIST_DEPTH + 1)),
             1'b0, pls_pkg::ST_OK);
    send_req(pls_pkg::OP_INS_POS, pick_value(), 8'd0, 1'b0, pls_pkg::ST_OK);
    send_req(pls_pkg::OP_INS_POS, pick_value(), POS_W'($urandom_range(LIST_DEPTH + 2, 255)),
             1'b0, pls_pkg::ST_OK);
    send_req(pls_pkg::OP_DUMP, pick_value(), 8'd0, 1'b0, pls_pkg::ST_OK);
  endtask

  task automatic drain_list();
    logic [OP_W-1:0] op;
    while (shadow_list.size() > 0) begin
      op = OP_W'($urandom_range(pls_pkg::OP_DEL_FRONT, pls_pkg::OP_DEL_POS));
      send_req(op, pick_value(), POS_W'($urandom_range(1, shadow_list.size())), 1'b0,
               pls_pkg::ST_OK);
    end
    send_req(pls_pkg::OP_DEL_FRONT, pick_value(), 8'd0, 1'b0, pls_pkg::ST_OK);
    send_req(pls_pkg::OP_DEL_END, pick_value(), 8'd0, 1'b0, pls_pkg::ST_OK);
    send_req(pls_pkg::OP_DEL_POS, pick_value(), POS_W'($urandom_range(0, 255)), 1'b0,
             pls_pkg::ST_OK);
    send_req(pls_pkg::OP_DUMP, pick_value(), 8'd0, 1'b0, pls_pkg::ST_OK);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_beats.size() == 0) begin
        $error("unexpected beat: status %0d element %0d last %0d",
               out_status, out_element, out_last);
        mismatches++;
      end else begin
        want = due_beats.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_element !== want.element) begin
          $error("element: expected %0d, actual %0d", $signed(want.element), out_element);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      n = ($urandom_range(0, 99) < 15) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int r;
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = pls_pkg::OP_INS_FRONT;
    in_value    = '0;
    in_position = '0;
    mismatches  = 0;
    cycle_cnt   = 0;
    sent_items  = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;

    //      op                     value          pos     typed status
    add_row(pls_pkg::OP_DUMP,      32'h0,         8'd0,   1'b1, pls_pkg::ST_EMPTY);
    add_row(pls_pkg::OP_DEL_FRONT, 32'h0,         8'd0,   1'b1, pls_pkg::ST_EMPTY);
    add_row(pls_pkg::OP_DEL_END,   32'h0,         8'd0,   1'b1, pls_pkg::ST_EMPTY);
    add_row(pls_pkg::OP_DEL_POS,   32'h0,         8'd0,   1'b1, pls_pkg::ST_EMPTY);
    add_row(pls_pkg::OP_INS_POS,   32'h1234_5678, 8'd0,   1'b1, pls_pkg::ST_INVALID);
    add_row(pls_pkg::OP_INS_POS,   32'h1234_5678, 8'd2,   1'b1, pls_pkg::ST_RANGE);
    add_row(OP_SPARE,              32'hffff_ffff, 8'd255, 1'b1, pls_pkg::ST_INVALID);
    add_row(pls_pkg::OP_INS_POS,   32'h8000_0000, 8'd1,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_INS_FRONT, 32'h7fff_ffff, 8'd0,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_INS_END,   32'hffff_ffff, 8'd0,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_INS_POS,   32'h0000_0001, 8'd4,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_INS_POS,   32'h0000_0002, 8'd255, 1'b1, pls_pkg::ST_RANGE);
    add_row(pls_pkg::OP_INS_POS,   32'h0000_0003, 8'd6,   1'b1, pls_pkg::ST_RANGE);
    add_row(pls_pkg::OP_DUMP,      32'h0,         8'd0,   1'b0, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_DEL_POS,   32'h0,         8'd0,   1'b1, pls_pkg::ST_INVALID);
    add_row(pls_pkg::OP_DEL_POS,   32'h0,         8'd5,   1'b1, pls_pkg::ST_RANGE);
    add_row(pls_pkg::OP_DEL_POS,   32'h0,         8'd4,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_DEL_POS,   32'h0,         8'd2,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_DEL_FRONT, 32'h0,         8'd0,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_DUMP,      32'h0,         8'd0,   1'b0, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_DEL_END,   32'h0,         8'd0,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_DUMP,      32'h0,         8'd0,   1'b1, pls_pkg::ST_EMPTY);
    add_row(pls_pkg::OP_INS_END,   32'h5555_5555, 8'd0,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_INS_POS,   32'haaaa_aaaa, 8'd1,   1'b1, pls_pkg::ST_OK);
    add_row(pls_pkg::OP_DUMP,      32'h0,         8'd0,   1'b0, pls_pkg::ST_OK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i])
      send_req(table_rows[i].op, table_rows[i].value, table_rows[i].position,
               table_rows[i].typed, table_rows[i].status);

    // hold the receiver off and keep offering beats so the input backs up
    hold_req = 1'b1;
    calm     = 1'b1;
    repeat (12) send_random_item();
    calm = 1'b0;
    fill_list();
    drain_list();

    while (sent_items < TOTAL_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        fill_list();
      end else if (r == 1) begin
        drain_list();
      end else if (r == 2) begin
        calm = 1'b1;
        repeat (8) send_random_item();
        calm = 1'b0;
      end else begin
        send_random_item();
      end
    end
    in_valid <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
